[hw/rtl/cip_pkg.sv]
// shared constants and types for the complex integer power block
package cip_pkg;

   // word format
   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int ACC_W     = PROD_W + 2;

   // exponent
   localparam int EXP_IN_W = 8;
   localparam int EXP_BITS = 8;
   localparam int IDX_W    = (EXP_BITS > 2) ? $clog2(EXP_BITS) : 1;

   // result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

   // request to the complex multiplier
   typedef struct packed {
      logic                     start;
      logic signed [WORD_W-1:0] a_re;
      logic signed [WORD_W-1:0] a_im;
      logic signed [WORD_W-1:0] b_re;
      logic signed [WORD_W-1:0] b_im;
   } cmul_req_type;

   // answer from the complex multiplier
   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [WORD_W-1:0] re;
      logic signed [WORD_W-1:0] im;
   } cmul_rsp_type;

endpackage

[hw/rtl/complex_integer_power.sv]
// complex integer power: top level sequencer around the shared complex multiplier
//
// Raises a signed Q16.16 complex base to a power of 1 to 255 by left-to-right
// square-and-multiply. Every complex multiply runs on one 32x32 multiplier in
// the cip_cmul unit; a squaring also passes through the check state. An
// exponent whose top set bit is at position t with m further set bits needs t
// squarings and m multiplies. A result still waiting in the output register
// holds the final check. Exponent one returns the base without a multiply,
// exponent zero returns zero with the error status. Each product is rounded to
// nearest (ties up) and saturated; any saturation along the way gives the
// saturated status.
// The block takes one word at a time; a finished result waits in the output
// register while the next word is already accepted.
module complex_integer_power
   import cip_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [WORD_W-1:0]   req_real_in,
   input  logic signed [WORD_W-1:0]   req_imag_in,
   input  logic [EXP_IN_W-1:0]        req_exponent,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_real_out,
   output logic signed [WORD_W-1:0]   rsp_imag_out,
   output logic [STATUS_W-1:0]        rsp_status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SQ_WAIT,
      ST_MUL_WAIT
   } state_type;

   state_type                state_ff;
   logic signed [WORD_W-1:0] br_ff, bi_ff, ar_ff, ai_ff;
   logic [EXP_BITS-1:0]      n_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic                     zero_ff;
   logic                     sat_ff;
   logic                     start_ff;
   logic                     use_base_ff;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_re_ff, rsp_im_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   logic [EXP_BITS-1:0]      n_in;
   logic [IDX_W-1:0]         top_in;
   logic [IDX_W-1:0]         idx_m1;
   logic                     out_free;
   logic                     rsp_load;
   cmul_req_type             cmul_req;
   cmul_rsp_type             cmul_rsp;

   // position of the highest set exponent bit
   function automatic logic [IDX_W-1:0] top_bit(input logic [EXP_BITS-1:0] n);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < EXP_BITS; i++) begin
         if (n[i]) begin
            pos = IDX_W'(i);
         end
      end
      return pos;
   endfunction

   assign n_in     = EXP_BITS'(req_exponent);
   assign top_in   = top_bit(n_in);
   assign idx_m1   = idx_ff - IDX_W'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == ST_CHECK) && (idx_ff == '0) && out_free;

   // shared complex multiplier
   assign cmul_req.start = start_ff;
   assign cmul_req.a_re  = ar_ff;
   assign cmul_req.a_im  = ai_ff;
   assign cmul_req.b_re  = use_base_ff ? br_ff : ar_ff;
   assign cmul_req.b_im  = use_base_ff ? bi_ff : ai_ff;

   cip_cmul u_cmul (
      .clock (clock),
      .reset (reset),
      .req   (cmul_req),
      .rsp   (cmul_rsp)
   );

   // exponent sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         // a new result replaces one leaving in the same cycle
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  br_ff    <= req_real_in;
                  bi_ff    <= req_imag_in;
                  ar_ff    <= req_real_in;
                  ai_ff    <= req_imag_in;
                  n_ff     <= n_in;
                  idx_ff   <= top_in;
                  zero_ff  <= (n_in == '0);
                  sat_ff   <= 1'b0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (idx_ff == '0) begin
                  if (out_free) begin
                     if (zero_ff) begin
                        rsp_re_ff     <= '0;
                        rsp_im_ff     <= '0;
                        rsp_status_ff <= STATUS_ERR;
                     end else begin
                        rsp_re_ff     <= ar_ff;
                        rsp_im_ff     <= ai_ff;
                        rsp_status_ff <= sat_ff ? STATUS_SAT : STATUS_OK;
                     end
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  start_ff    <= 1'b1;
                  use_base_ff <= 1'b0;
                  state_ff    <= ST_SQ_WAIT;
               end
            end
            ST_SQ_WAIT: begin
               if (cmul_rsp.done) begin
                  ar_ff  <= cmul_rsp.re;
                  ai_ff  <= cmul_rsp.im;
                  sat_ff <= sat_ff | cmul_rsp.sat;
                  if (n_ff[idx_m1]) begin
                     start_ff    <= 1'b1;
                     use_base_ff <= 1'b1;
                     state_ff    <= ST_MUL_WAIT;
                  end else begin
                     idx_ff   <= idx_m1;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_MUL_WAIT: begin
               if (cmul_rsp.done) begin
                  ar_ff    <= cmul_rsp.re;
                  ai_ff    <= cmul_rsp.im;
                  sat_ff   <= sat_ff | cmul_rsp.sat;
                  idx_ff   <= idx_m1;
                  state_ff <= ST_CHECK;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_real_out = rsp_re_ff;
   assign rsp_imag_out = rsp_im_ff;
   assign rsp_status   = rsp_status_ff;

   // multiplier finishes only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cmul_rsp.done |-> (state_ff == ST_SQ_WAIT || state_ff == ST_MUL_WAIT))
      else $error("multiplier done outside a wait state");

   // a multiply is launched only on entry to a wait state
   a_start_in_wait: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == ST_SQ_WAIT || state_ff == ST_MUL_WAIT))
      else $error("multiplier started outside a wait state");

   // rejected exponent always carries a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ERR) |-> (rsp_real_out == '0 && rsp_imag_out == '0))
      else $error("error status with nonzero result");

endmodule

[hw/rtl/cip_cmul.sv]
// complex multiplier on one shared 32x32 multiplier, rounded and saturated
module cip_cmul
   import cip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmul_req_type req,
   output cmul_rsp_type rsp
);

   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] MAX_ACC = ACC_W'({1'b0, {(WORD_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] MIN_ACC = -(ACC_W'(1) <<< (WORD_W - 1));
   localparam logic signed [WORD_W-1:0] MAX_W  = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] MIN_W  = {1'b1, {(WORD_W-1){1'b0}}};

   logic                     busy_ff;
   logic [2:0]               cnt_ff;
   logic signed [WORD_W-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [WORD_W-1:0] re_ff, im_ff;
   logic                     sat_ff;
   logic                     done_ff;

   logic signed [WORD_W-1:0] mul_x, mul_y;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  rnd_sum, rnd_shift;
   logic                     rnd_hi, rnd_lo;
   logic signed [WORD_W-1:0] rnd_word;

   // operand pair per step: ac, bd, ad, bc
   always_comb begin
      unique case (cnt_ff)
         3'd1: begin
            mul_x = a_im_ff;
            mul_y = b_im_ff;
         end
         3'd2: begin
            mul_x = a_re_ff;
            mul_y = b_im_ff;
         end
         3'd3: begin
            mul_x = a_im_ff;
            mul_y = b_re_ff;
         end
         default: begin
            mul_x = a_re_ff;
            mul_y = b_re_ff;
         end
      endcase
   end

   assign prod_in  = mul_x * mul_y;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // round half up to the word format and clamp
   assign rnd_sum   = acc_ff + HALF;
   assign rnd_shift = rnd_sum >>> FRAC_BITS;
   assign rnd_hi    = rnd_shift > MAX_ACC;
   assign rnd_lo    = rnd_shift < MIN_ACC;

   always_comb begin
      priority if (rnd_hi) begin
         rnd_word = MAX_W;
      end else if (rnd_lo) begin
         rnd_word = MIN_W;
      end else begin
         rnd_word = rnd_shift[WORD_W-1:0];
      end
   end

   // step sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (req.start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= 3'd0;
            end
         end else begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (!busy_ff && req.start) begin
         a_re_ff <= req.a_re;
         a_im_ff <= req.a_im;
         b_re_ff <= req.b_re;
         b_im_ff <= req.b_im;
         sat_ff  <= 1'b0;
      end
      if (busy_ff) begin
         prod_ff <= prod_in;
         unique case (cnt_ff)
            3'd1: acc_ff <= prod_ext;
            3'd2: acc_ff <= acc_ff - prod_ext;
            3'd3: begin
               re_ff  <= rnd_word;
               sat_ff <= rnd_hi | rnd_lo;
               acc_ff <= prod_ext;
            end
            3'd4: acc_ff <= acc_ff + prod_ext;
            3'd5: begin
               im_ff  <= rnd_word;
               sat_ff <= sat_ff | rnd_hi | rnd_lo;
            end
            default: ;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;
   assign rsp.re   = re_ff;
   assign rsp.im   = im_ff;

endmodule
